FILE: rtl/even_odd_lattice_neighbor_index_defines.svh
// ----------------------------------------------------------------------------
// Even-odd lattice neighbor index: assertion macros
// Shared concurrent assertion forms clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EVEN_ODD_LATTICE_NEIGHBOR_INDEX_DEFINES_SVH
`define EVEN_ODD_LATTICE_NEIGHBOR_INDEX_DEFINES_SVH

// plain implication checked at every edge
`define EOLN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition now implies a consequence at the next edge
`define EOLN_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/eoln_pkg.sv
// ----------------------------------------------------------------------------
// Even-odd lattice neighbor index: package
// Pipeline word type, field widths and code constants.
// ----------------------------------------------------------------------------
package eoln_pkg;

  localparam int unsigned IdxW  = 19;
  localparam int unsigned ExtW  = 6;
  localparam int unsigned HxW   = 5;
  localparam int unsigned CfgIW = 3;
  localparam int unsigned InW   = 32;
  localparam int unsigned OutW  = 24;

  typedef enum logic [1:0] {
    DIR_X = 2'd0,
    DIR_Y = 2'd1,
    DIR_Z = 2'd2,
    DIR_T = 2'd3
  } dir_e;

  typedef enum logic [CfgIW-1:0] {
    CFG_HALF_X = 3'd0,
    CFG_Y      = 3'd1,
    CFG_Z      = 3'd2,
    CFG_T      = 3'd3,
    CFG_POFF   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SAVE_NONE = 2'd0,
    SAVE_X    = 2'd1,
    SAVE_Y    = 2'd2
  } save_e;

  typedef enum logic [1:0] {
    PH_STEP = 2'd0,
    PH_MULZ = 2'd1,
    PH_MULY = 2'd2,
    PH_MULX = 2'd3
  } phase_e;

  typedef struct packed {
    logic              down;
    dir_e              dir;
    logic              par;
    logic signed [1:0] bf;
    logic              crossed;
    logic [HxW-1:0]    ix2;
    logic [ExtW-1:0]   iy;
    logic [ExtW-1:0]   iz;
    logic [IdxW-1:0]   num;
    logic [IdxW-1:0]   quo;
    logic [ExtW-1:0]   rem;
  } pipe_t;

endpackage

FILE: rtl/eoln_div_stage.sv
// ----------------------------------------------------------------------------
// Even-odd lattice neighbor index: divider stage
// A few restoring division steps on the carried index, then a register.
// ----------------------------------------------------------------------------
module eoln_div_stage #(
  parameter int unsigned STEPS = 5,
  parameter bit          FIRST = 1'b0,
  parameter int unsigned SAVE  = 0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [eoln_pkg::ExtW-1:0]       divisor_i,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  eoln_pkg::pipe_t                 item_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output eoln_pkg::pipe_t                 item_o
);
  import eoln_pkg::*;

  pipe_t                item_d, item_q;
  logic                 valid_q;
  logic [ExtW:0]        t;

  always_comb begin
    item_d = item_i;
    t      = '0;
    if (FIRST) begin
      item_d.num = item_i.quo;
      item_d.quo = '0;
      item_d.rem = '0;
      if (SAVE == SAVE_X) begin
        item_d.ix2 = item_i.rem[HxW-1:0];
      end else if (SAVE == SAVE_Y) begin
        item_d.iy = item_i.rem;
      end
    end
    for (int k = 0; k < STEPS; k++) begin
      t          = {item_d.rem, item_d.num[IdxW-1]};
      item_d.num = {item_d.num[IdxW-2:0], 1'b0};
      if (t >= {1'b0, divisor_i}) begin
        item_d.rem = ExtW'(t - {1'b0, divisor_i});
        item_d.quo = {item_d.quo[IdxW-2:0], 1'b1};
      end else begin
        item_d.rem = t[ExtW-1:0];
        item_d.quo = {item_d.quo[IdxW-2:0], 1'b0};
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/eoln_post_stage.sv
// ----------------------------------------------------------------------------
// Even-odd lattice neighbor index: post stage
// Neighbor step on the coordinates, or one multiply-add of the index rebuild.
// ----------------------------------------------------------------------------
module eoln_post_stage #(
  parameter int unsigned PHASE = 0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [eoln_pkg::HxW-1:0]        nx2_i,
  input  logic [eoln_pkg::ExtW-1:0]       ny_i,
  input  logic [eoln_pkg::ExtW-1:0]       nz_i,
  input  logic [eoln_pkg::ExtW-1:0]       nt_i,
  input  logic                            poff_i,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  eoln_pkg::pipe_t                 item_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output eoln_pkg::pipe_t                 item_o
);
  import eoln_pkg::*;

  pipe_t          item_d, item_q;
  logic           valid_q;
  logic           keo;
  logic [HxW:0]   xs;
  logic [ExtW:0]  ys, zs;
  logic [IdxW:0]  ts;

  always_comb begin
    item_d = item_i;
    keo    = item_i.par ^ item_i.iy[0] ^ item_i.rem[0] ^ item_i.quo[0] ^ poff_i;
    xs     = {1'b0, item_i.ix2} + {{HxW{1'b0}}, keo};
    ys     = {1'b0, item_i.iy} + 1'b1;
    zs     = {1'b0, item_i.rem} + 1'b1;
    ts     = {1'b0, item_i.quo} + 1'b1;
    case (PHASE)
      PH_STEP: begin
        item_d.iz      = item_i.rem;
        item_d.crossed = 1'b0;
        case (item_i.dir)
          DIR_X: begin
            if (!item_i.down) begin
              if (xs < {1'b0, nx2_i}) begin
                item_d.ix2 = xs[HxW-1:0];
              end else begin
                item_d.ix2 = '0;
                item_d.crossed = 1'b1;
              end
            end else if (!keo && item_i.ix2 == '0) begin
              item_d.ix2 = nx2_i - 1'b1;
              item_d.crossed = 1'b1;
            end else begin
              item_d.ix2 = item_i.ix2 - {{(HxW-1){1'b0}}, !keo};
            end
          end
          DIR_Y: begin
            if (!item_i.down) begin
              if (ys < {1'b0, ny_i}) begin
                item_d.iy = ys[ExtW-1:0];
              end else begin
                item_d.iy = '0;
                item_d.crossed = 1'b1;
              end
            end else if (item_i.iy == '0) begin
              item_d.iy = ny_i - 1'b1;
              item_d.crossed = 1'b1;
            end else begin
              item_d.iy = item_i.iy - 1'b1;
            end
          end
          DIR_Z: begin
            if (!item_i.down) begin
              if (zs < {1'b0, nz_i}) begin
                item_d.iz = zs[ExtW-1:0];
              end else begin
                item_d.iz = '0;
                item_d.crossed = 1'b1;
              end
            end else if (item_i.rem == '0) begin
              item_d.iz = nz_i - 1'b1;
              item_d.crossed = 1'b1;
            end else begin
              item_d.iz = item_i.rem - 1'b1;
            end
          end
          default: begin
            if (!item_i.down) begin
              if (ts < {{(IdxW-ExtW+1){1'b0}}, nt_i}) begin
                item_d.quo = ts[IdxW-1:0];
              end else begin
                item_d.quo = '0;
                item_d.crossed = 1'b1;
              end
            end else if (item_i.quo == '0) begin
              item_d.quo = {{(IdxW-ExtW){1'b0}}, nt_i - 1'b1};
              item_d.crossed = 1'b1;
            end else begin
              item_d.quo = item_i.quo - 1'b1;
            end
          end
        endcase
        if (!item_d.crossed) begin
          item_d.bf = 2'sb01;
        end
      end
      PH_MULZ: item_d.quo = IdxW'({{(IdxW-ExtW){1'b0}}, item_i.iz} + nz_i * item_i.quo);
      PH_MULY: item_d.quo = IdxW'({{(IdxW-ExtW){1'b0}}, item_i.iy} + ny_i * item_i.quo);
      default: item_d.quo = IdxW'({{(IdxW-HxW){1'b0}}, item_i.ix2} + nx2_i * item_i.quo);
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/even_odd_lattice_neighbor_index.sv
// ----------------------------------------------------------------------------
// Even-odd lattice neighbor index: top level
// A new site word is taken every cycle unless stalled. Twelve divider stages
// split the site index by the x, y and z extents (five restoring steps per
// stage, one fewer in each extent's last), one stage steps the coordinate,
// and three multiply-add stages rebuild the neighbor index, the last being
// the output register. Each stage has its own valid bit, holding under stall.
// ----------------------------------------------------------------------------
module even_odd_lattice_neighbor_index #(
  parameter int unsigned MAX_EXTENT = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [eoln_pkg::CfgIW-1:0]   cfg_idx_i,
  input  logic [eoln_pkg::ExtW-1:0]    cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // cmd, direction[1:0], site_parity, site_index[18:0], boundary_factor[1:0]
  input  logic [eoln_pkg::InW-1:0]     s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // neighbor_index[18:0], crossed_edge, scale[1:0]
  output logic [eoln_pkg::OutW-1:0]    m_axis_tdata
);
  import eoln_pkg::*;

  localparam int unsigned NDiv  = 12;
  localparam int unsigned NPost = 4;
  localparam int unsigned NSt   = NDiv + NPost;

  logic [HxW-1:0]  nx2_q;
  logic [ExtW-1:0] ny_q, nz_q, nt_q;
  logic            poff_q;

  pipe_t s_item;
  pipe_t link [0:NSt];
  logic  vld  [0:NSt];
  logic  rdy  [0:NSt];

  function automatic logic [ExtW-1:0] clamp_ext(logic [ExtW-1:0] v, int unsigned maxv);
    logic [ExtW-1:0] r;
    if (v == '0) begin
      r = ExtW'(1);
    end else if (int'(v) > int'(maxv)) begin
      r = ExtW'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx2_q  <= HxW'(4);
      ny_q   <= ExtW'(8);
      nz_q   <= ExtW'(8);
      nt_q   <= ExtW'(8);
      poff_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_HALF_X: nx2_q  <= HxW'(clamp_ext({1'b0, cfg_wdata_i[HxW-1:0]}, MAX_EXTENT / 2));
        CFG_Y:      ny_q   <= clamp_ext(cfg_wdata_i, MAX_EXTENT);
        CFG_Z:      nz_q   <= clamp_ext(cfg_wdata_i, MAX_EXTENT);
        CFG_T:      nt_q   <= clamp_ext(cfg_wdata_i, MAX_EXTENT);
        CFG_POFF:   poff_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s_item          = '0;
    s_item.down     = s_axis_tdata[0];
    s_item.dir      = dir_e'(s_axis_tdata[2:1]);
    s_item.par      = s_axis_tdata[3];
    s_item.quo      = s_axis_tdata[22:4];
    s_item.bf       = s_axis_tdata[24:23];
  end

  assign link[0]       = s_item;
  assign vld[0]        = s_axis_tvalid;
  assign s_axis_tready = rdy[0];

  for (genvar j = 0; j < NDiv; j++) begin : g_div
    logic [ExtW-1:0] dvs;
    assign dvs = (j / 4 == 0) ? {1'b0, nx2_q} : (j / 4 == 1) ? ny_q : nz_q;
    eoln_div_stage #(
      .STEPS ((j % 4 == 3) ? 4 : 5),
      .FIRST (j % 4 == 0),
      .SAVE  (j / 4)
    ) u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .divisor_i (dvs),
      .valid_i   (vld[j]),
      .ready_o   (rdy[j]),
      .item_i    (link[j]),
      .valid_o   (vld[j+1]),
      .ready_i   (rdy[j+1]),
      .item_o    (link[j+1])
    );
  end

  for (genvar p = 0; p < NPost; p++) begin : g_post
    eoln_post_stage #(
      .PHASE (p)
    ) u_post (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .nx2_i   (nx2_q),
      .ny_i    (ny_q),
      .nz_i    (nz_q),
      .nt_i    (nt_q),
      .poff_i  (poff_q),
      .valid_i (vld[NDiv+p]),
      .ready_o (rdy[NDiv+p]),
      .item_i  (link[NDiv+p]),
      .valid_o (vld[NDiv+p+1]),
      .ready_i (rdy[NDiv+p+1]),
      .item_o  (link[NDiv+p+1])
    );
  end

  assign rdy[NSt]      = m_axis_tready;
  assign m_axis_tvalid = vld[NSt];
  assign m_axis_tdata  = {2'b00, link[NSt].bf, link[NSt].crossed, link[NSt].quo};

endmodule

FILE: rtl/eoln_checker.sv
// ----------------------------------------------------------------------------
// Even-odd lattice neighbor index: port checker
// Watches the output stream of the top level and is bound to it.
// ----------------------------------------------------------------------------
`include "even_odd_lattice_neighbor_index_defines.svh"

module eoln_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [eoln_pkg::OutW-1:0]   m_axis_tdata
);
  import eoln_pkg::*;

  `EOLN_ASSERT_NEXT(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output word dropped under stall")
  `EOLN_ASSERT_NEXT(a_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "output word changed under stall")
  `EOLN_ASSERT(a_scale_one, !(m_axis_tvalid && !m_axis_tdata[19]) || m_axis_tdata[21:20] == 2'b01, "scale not one without crossing")
  `EOLN_ASSERT(a_pad_zero, !m_axis_tvalid || m_axis_tdata[23:22] == 2'b00, "output pad bits not zero")

endmodule

bind even_odd_lattice_neighbor_index eoln_checker u_eoln_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
